// File: rtl/core/ptbl_pkg.sv
// Shared constants for the per-address token bucket limiter.
// No dependencies; imported by ptbl_in_if, the cells, the refill unit and the top level.
package ptbl_pkg;

  localparam int ADDR_W  = 32;
  localparam int TOKEN_W = 32;
  localparam int NOW_W   = 48;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int TIME_BITS_DEF     = 48;

  localparam logic [31:0] RATE_RESET  = 32'd65536;
  localparam logic [15:0] BURST_RESET = 16'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST = 2'd1;

  localparam logic [1:0] CHG_ENTRY = 2'd0;
  localparam logic [1:0] CHG_NEW   = 2'd1;
  localparam logic [1:0] CHG_SPILL = 2'd2;

endpackage

// File: rtl/core/ptbl_ifs.sv
// Valid/ready channel interfaces for requests and results.
// ptbl_in_if depends on ptbl_pkg for field widths.
interface ptbl_in_if import ptbl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] ip_address;
  logic [NOW_W-1:0]  now_ticks;
  modport source (output valid, output ip_address, output now_ticks, input ready);
  modport sink   (input valid, input ip_address, input now_ticks, output ready);
endinterface

interface ptbl_out_if ();
  logic       valid;
  logic       ready;
  logic       allowed;
  logic [1:0] charged_to;
  modport source (output valid, output allowed, output charged_to, input ready);
  modport sink   (input valid, input allowed, input charged_to, output ready);
endinterface

// File: rtl/core/per_address_token_bucket_limiter.sv
// Per-address token bucket limiter: a ring of bucket cells plus a shared refill unit.
// A hit passes lookup, a refill wait and the charge; an insert commits from lookup.
// A full-table miss first turns the ring through cells and refill, then looks up again.
// One request at a time: the next is taken once the last one commits, and a commit
// waits while an unread result is held; a new request is taken while a result waits.
// Synchronous active-low reset empties the table and zeroes the spill bucket.
module per_address_token_bucket_limiter import ptbl_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ptbl_in_if.sink              in_ch,
  ptbl_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int N     = TABLE_ENTRIES;
  localparam int CNT_W = $clog2(N + 3);
  localparam logic [CNT_W-1:0] PRUNE_LAST = CNT_W'(N + 1);
  localparam logic [TOKEN_W-1:0] ONE_TOKEN = TOKEN_W'(1) << FRACTION_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_PRUNE = 3'd2;
  localparam logic [2:0] S_CHG   = 3'd3;

  logic [2:0]       state_r;
  logic             chg_wait_r;
  logic             pruned_r;
  logic [CNT_W-1:0] cnt_r;
  logic [N-1:0]     sel_r;
  logic             spill_sel_r;

  logic [31:0] rate_r;
  logic [15:0] burst_r;
  logic [ADDR_W-1:0]    req_addr_r;
  logic [NOW_W-1:0]     req_now_r;
  logic [TOKEN_W-1:0]   spill_tok_r;
  logic [TIME_BITS-1:0] spill_last_r;

  logic       out_valid_r;
  logic       allowed_r;
  logic [1:0] who_r;

  logic [63:0]          capw;
  logic [TOKEN_W-1:0]   cap;
  logic [TIME_BITS-1:0] now_t;

  logic                 cv [N];
  logic [ADDR_W-1:0]    ca [N];
  logic [TOKEN_W-1:0]   ct [N];
  logic [TIME_BITS-1:0] cl [N];
  logic [N-1:0]         match_v, free_v, hit_1h, free_1h, wr_v;
  logic                 any_hit, any_free;
  logic [TOKEN_W-1:0]   hit_tok;
  logic [TIME_BITS-1:0] hit_last;

  logic                 shift;
  logic                 adv;
  logic [TOKEN_W-1:0]   u_tok;
  logic [TIME_BITS-1:0] u_last;
  logic                 u_pv;
  logic [TOKEN_W-1:0]   r_ref, r_tok;
  logic                 r_pv;
  logic [ADDR_W-1:0]    r_pa;
  logic [TIME_BITS-1:0] r_pl;

  logic               out_free;
  logic               commit_chg, commit_ins;
  logic               ok;
  logic [TOKEN_W-1:0] new_tok, ins_tok, wr_tok;

  assign capw  = 64'(burst_r) << FRACTION_BITS;
  assign cap   = (capw > 64'h0000_0000_FFFF_FFFF) ? '1 : capw[TOKEN_W-1:0];
  assign now_t = TIME_BITS'(req_now_r);
  assign ins_tok = (cap >= ONE_TOKEN) ? (cap - ONE_TOKEN) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= RATE_RESET;
      burst_r <= BURST_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RATE:  rate_r  <= cfg_wdata;
        CFG_BURST: burst_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign shift = (state_r == S_PRUNE);

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      logic                 pv;
      logic [ADDR_W-1:0]    pa;
      logic [TOKEN_W-1:0]   pt;
      logic [TIME_BITS-1:0] pl;
      if (g == 0) begin : g_head
        // drop entries that would be full anyway as they come back round
        assign pv = r_pv && (r_ref < cap);
        assign pa = r_pa;
        assign pt = r_tok;
        assign pl = r_pl;
      end else begin : g_body
        assign pv = cv[g-1];
        assign pa = ca[g-1];
        assign pt = ct[g-1];
        assign pl = cl[g-1];
      end
      ptbl_cell #(.TIME_BITS(TIME_BITS)) u_cell (
        .clk(clk), .rst_n(rst_n), .shift(shift), .wr(wr_v[g]), .key(req_addr_r),
        .prev_valid(pv), .prev_addr(pa), .prev_tokens(pt), .prev_last(pl),
        .wr_addr(req_addr_r), .wr_tokens(wr_tok), .wr_last(now_t),
        .valid(cv[g]), .addr(ca[g]), .tokens(ct[g]), .last(cl[g]), .match(match_v[g])
      );
      assign free_v[g] = !cv[g];
    end
  endgenerate

  assign hit_1h   = match_v & (~match_v + N'(1));
  assign free_1h  = free_v & (~free_v + N'(1));
  assign any_hit  = |match_v;
  assign any_free = |free_v;

  always_comb begin
    hit_tok  = '0;
    hit_last = '0;
    for (int i = 0; i < N; i++) begin
      hit_tok  = hit_tok  | (ct[i] & {TOKEN_W{hit_1h[i]}});
      hit_last = hit_last | (cl[i] & {TIME_BITS{hit_1h[i]}});
    end
  end

  always_comb begin
    if (state_r == S_PRUNE) begin
      u_tok  = ct[N-1];
      u_last = cl[N-1];
      u_pv   = cv[N-1];
    end else if (any_hit) begin
      u_tok  = hit_tok;
      u_last = hit_last;
      u_pv   = 1'b0;
    end else begin
      u_tok  = spill_tok_r;
      u_last = spill_last_r;
      u_pv   = 1'b0;
    end
  end

  assign adv = !((state_r == S_CHG) && !chg_wait_r);

  ptbl_refill #(.TIME_BITS(TIME_BITS)) u_refill (
    .clk(clk), .rst_n(rst_n), .adv(adv), .rate(rate_r), .cap(cap), .now(now_t),
    .tokens(u_tok), .last(u_last), .pv_in(u_pv), .pa_in(ca[N-1]),
    .refilled(r_ref), .tokens_out(r_tok), .pv_out(r_pv), .pa_out(r_pa), .pl_out(r_pl)
  );

  assign out_free   = !out_valid_r || out_ch.ready;
  assign commit_chg = (state_r == S_CHG) && !chg_wait_r && out_free;
  assign commit_ins = (state_r == S_LOOK) && !any_hit && any_free && out_free;
  assign ok         = (r_ref >= ONE_TOKEN);
  assign new_tok    = ok ? (r_ref - ONE_TOKEN) : r_ref;
  assign wr_tok     = (state_r == S_LOOK) ? ins_tok : new_tok;

  always_comb begin
    wr_v = '0;
    if (commit_ins) begin
      wr_v = free_1h;
    end else if (commit_chg && !spill_sel_r) begin
      wr_v = sel_r;
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chg_wait_r  <= 1'b0;
      pruned_r    <= 1'b0;
      cnt_r       <= '0;
      spill_sel_r <= 1'b0;
      sel_r       <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            state_r  <= S_LOOK;
            pruned_r <= 1'b0;
          end
        end
        S_LOOK: begin
          priority if (any_hit) begin
            sel_r       <= hit_1h;
            spill_sel_r <= 1'b0;
            chg_wait_r  <= 1'b1;
            state_r     <= S_CHG;
          end else if (any_free) begin
            if (out_free) begin
              state_r <= S_IDLE;
            end
          end else if (!pruned_r) begin
            cnt_r   <= '0;
            state_r <= S_PRUNE;
          end else begin
            sel_r       <= '0;
            spill_sel_r <= 1'b1;
            chg_wait_r  <= 1'b1;
            state_r     <= S_CHG;
          end
        end
        S_PRUNE: begin
          // full turn of the ring including the two refill stages
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == PRUNE_LAST) begin
            pruned_r <= 1'b1;
            state_r  <= S_LOOK;
          end
        end
        S_CHG: begin
          if (chg_wait_r) begin
            chg_wait_r <= 1'b0;
          end else if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_addr_r <= in_ch.ip_address;
      req_now_r  <= in_ch.now_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spill_tok_r  <= '0;
      spill_last_r <= '0;
    end else if (commit_chg && spill_sel_r) begin
      spill_tok_r  <= new_tok;
      spill_last_r <= now_t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit_chg || commit_ins) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_ins) begin
      allowed_r <= 1'b1;
      who_r     <= CHG_NEW;
    end else if (commit_chg) begin
      allowed_r <= ok;
      who_r     <= spill_sel_r ? CHG_SPILL : CHG_ENTRY;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.allowed    = allowed_r;
  assign out_ch.charged_to = who_r;

`ifndef SYNTH
  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHG) |-> $onehot({spill_sel_r, sel_r}))
    else $error("charge target not unique");

  a_hit_lowest: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK) |-> ($onehot0(hit_1h) && (any_hit == (hit_1h != '0))))
    else $error("hit select not one slot");

  a_no_write_in_prune: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PRUNE) |-> (wr_v == '0) && !out_valid_r || (state_r != S_PRUNE) ||
    (wr_v == '0))
    else $error("slot written during pruning");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(allowed_r) &&
    $stable(who_r)))
    else $error("pending result changed");
`endif

endmodule

// File: rtl/core/ptbl_cell.sv
// One bucket slot of the table: valid, key, token count and last-seen time.
// Depends on ptbl_pkg; cells form a ring that shifts by one during pruning.
module ptbl_cell import ptbl_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 shift,
  input  logic                 wr,
  input  logic [ADDR_W-1:0]    key,
  input  logic                 prev_valid,
  input  logic [ADDR_W-1:0]    prev_addr,
  input  logic [TOKEN_W-1:0]   prev_tokens,
  input  logic [TIME_BITS-1:0] prev_last,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  logic [TOKEN_W-1:0]   wr_tokens,
  input  logic [TIME_BITS-1:0] wr_last,
  output logic                 valid,
  output logic [ADDR_W-1:0]    addr,
  output logic [TOKEN_W-1:0]   tokens,
  output logic [TIME_BITS-1:0] last,
  output logic                 match
);

  logic                 valid_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [TOKEN_W-1:0]   tokens_r;
  logic [TIME_BITS-1:0] last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= prev_valid;
    end else if (wr) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      addr_r   <= prev_addr;
      tokens_r <= prev_tokens;
      last_r   <= prev_last;
    end else if (wr) begin
      addr_r   <= wr_addr;
      tokens_r <= wr_tokens;
      last_r   <= wr_last;
    end
  end

  assign valid  = valid_r;
  assign addr   = addr_r;
  assign tokens = tokens_r;
  assign last   = last_r;
  assign match  = valid_r && (addr_r == key);

endmodule

// File: rtl/core/ptbl_refill.sv
// Two-stage lazy refill: elapsed time, saturating product, add and cap.
// Depends on ptbl_pkg; carries an entry alongside so pruning can stream through it.
module ptbl_refill import ptbl_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic [31:0]          rate,
  input  logic [TOKEN_W-1:0]   cap,
  input  logic [TIME_BITS-1:0] now,
  input  logic [TOKEN_W-1:0]   tokens,
  input  logic [TIME_BITS-1:0] last,
  input  logic                 pv_in,
  input  logic [ADDR_W-1:0]    pa_in,
  output logic [TOKEN_W-1:0]   refilled,
  output logic [TOKEN_W-1:0]   tokens_out,
  output logic                 pv_out,
  output logic [ADDR_W-1:0]    pa_out,
  output logic [TIME_BITS-1:0] pl_out
);

  logic [TIME_BITS-1:0] elapsed;
  logic [63:0]          el64;

  logic                 s1_pv_r, s2_pv_r;
  logic [ADDR_W-1:0]    s1_pa_r, s2_pa_r;
  logic [TIME_BITS-1:0] s1_pl_r, s2_pl_r;
  logic [TOKEN_W-1:0]   s1_tok_r, s2_tok_r;
  logic [31:0]          s1_lo_r;
  logic                 s1_big_r, s2_big_r;
  logic [63:0]          s2_prod_r;

  logic [TOKEN_W-1:0] added;
  logic [TOKEN_W:0]   sum;

  assign elapsed = now - last;
  assign el64    = 64'(elapsed);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_pv_r <= 1'b0;
      s2_pv_r <= 1'b0;
    end else if (adv) begin
      s1_pv_r <= pv_in;
      s2_pv_r <= s1_pv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pa_r   <= pa_in;
      s1_pl_r   <= last;
      s1_tok_r  <= tokens;
      s1_lo_r   <= el64[31:0];
      s1_big_r  <= |el64[63:32];
      s2_pa_r   <= s1_pa_r;
      s2_pl_r   <= s1_pl_r;
      s2_tok_r  <= s1_tok_r;
      s2_big_r  <= s1_big_r;
      s2_prod_r <= 64'(s1_lo_r) * 64'(rate);
    end
  end

  // elapsed beyond 32 bits with a non-zero rate always overshoots the cap
  always_comb begin
    if (rate == 32'd0) begin
      added = '0;
    end else if (s2_big_r || (s2_prod_r > 64'(cap))) begin
      added = cap;
    end else begin
      added = s2_prod_r[TOKEN_W-1:0];
    end
    sum = (TOKEN_W+1)'(s2_tok_r) + (TOKEN_W+1)'(added);
    refilled = (sum > (TOKEN_W+1)'(cap)) ? cap : sum[TOKEN_W-1:0];
  end

  assign tokens_out = s2_tok_r;
  assign pv_out     = s2_pv_r;
  assign pa_out     = s2_pa_r;
  assign pl_out     = s2_pl_r;

endmodule

// File: test/per_address_token_bucket_limiter_tb.sv
// Self-checking testbench for the per-address token bucket limiter.
// Depends on ptbl_pkg and the ptbl_in_if / ptbl_out_if channel interfaces from the RTL.
module per_address_token_bucket_limiter_tb;
  import ptbl_pkg::*;

  localparam int SLOTS = TABLE_ENTRIES_DEF;
  localparam int FRAC = FRACTION_BITS_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam int SETTLE = SLOTS + 16;

  typedef struct packed {
    logic       allowed;
    logic [1:0] charged_to;
  } verdict_t;

  class bucket_scoreboard;
    logic [31:0] rate;
    logic [15:0] burst;
    bit          used[SLOTS];
    logic [31:0] key[SLOTS];
    logic [31:0] tok[SLOTS];
    logic [47:0] seen[SLOTS];
    logic [31:0] spill_tok;
    logic [47:0] spill_seen;
    verdict_t    owed[$];
    int          errors;

    function new();
      rate = RATE_RESET;
      burst = BURST_RESET;
      foreach (used[i]) used[i] = 0;
      spill_tok = '0;
      spill_seen = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_RATE) rate = val;
      else if (idx == CFG_BURST) burst = val[15:0];
    endfunction

    function logic [63:0] cap();
      return 64'(burst) << FRAC;
    endfunction

    function logic [63:0] topped(logic [31:0] t, logic [47:0] last, logic [47:0] now);
      logic [47:0] el;
      logic [63:0] added;
      logic [63:0] sum;
      el = now - last;
      if (rate == 0) added = '0;
      else if (64'(el) > cap() / 64'(rate)) added = cap();
      else added = 64'(el) * 64'(rate);
      sum = 64'(t) + added;
      return (sum > cap()) ? cap() : sum;
    endfunction

    // Slot -1 stands for the shared spill bucket.
    function bit spend(int s, logic [47:0] now);
      logic [63:0] t;
      bit ok;
      t = (s < 0) ? topped(spill_tok, spill_seen, now) : topped(tok[s], seen[s], now);
      ok = 0;
      if (t >= (64'd1 << FRAC)) begin
        t -= 64'd1 << FRAC;
        ok = 1;
      end
      if (s < 0) begin
        spill_tok = t[31:0];
        spill_seen = now;
      end else begin
        tok[s] = t[31:0];
        seen[s] = now;
      end
      return ok;
    endfunction

    function int first_free();
      for (int i = 0; i < SLOTS; i++) if (!used[i]) return i;
      return -1;
    endfunction

    function void note_request(logic [31:0] addr, logic [47:0] now);
      verdict_t v;
      int hit;
      int s;
      hit = -1;
      for (int i = 0; i < SLOTS; i++)
        if (used[i] && key[i] == addr) begin
          hit = i;
          break;
        end
      if (hit >= 0) begin
        v.allowed = spend(hit, now);
        v.charged_to = CHG_ENTRY;
      end else begin
        s = first_free();
        if (s < 0) begin
          // prune every bucket that would be full again
          for (int i = 0; i < SLOTS; i++)
            if (used[i] && topped(tok[i], seen[i], now) >= cap()) used[i] = 0;
          s = first_free();
        end
        if (s < 0) begin
          v.allowed = spend(-1, now);
          v.charged_to = CHG_SPILL;
        end else begin
          used[s] = 1;
          key[s] = addr;
          tok[s] = (cap() >= (64'd1 << FRAC)) ? 32'(cap() - (64'd1 << FRAC)) : '0;
          seen[s] = now;
          v.allowed = 1;
          v.charged_to = CHG_NEW;
        end
      end
      owed.push_back(v);
    endfunction

    function void check_result(logic allowed, logic [1:0] charged_to);
      verdict_t e;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result allowed=%b charged_to=%0d",
                                   allowed, charged_to);
        return;
      end
      e = owed.pop_front();
      if (allowed !== e.allowed || charged_to !== e.charged_to) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected allowed=%b charged_to=%0d, got allowed=%b charged_to=%0d",
                   e.allowed, e.charged_to, allowed, charged_to);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  ptbl_in_if in_ch ();
  ptbl_out_if out_ch ();

  per_address_token_bucket_limiter u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  bucket_scoreboard sb = new();
  bit quiet;
  bit hold_sink;
  logic [31:0] addr_pool[96];
  logic [47:0] clock_now;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_request(in_ch.ip_address, in_ch.now_ticks);
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.allowed, out_ch.charged_to);
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_sink) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_sink = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic send_req(logic [31:0] addr, logic [47:0] now);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.ip_address <= addr;
    in_ch.now_ticks <= now;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Hold the request side until every result is back and the block has settled.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
  endtask

  task automatic random_traffic(int count);
    logic [31:0] a;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) a = addr_pool[$urandom_range(0, 95)];
      else a = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 3) clock_now = 48'({$urandom, $urandom});
      else if (pick < 5) clock_now = clock_now - $urandom_range(1, 40);
      else if (pick < 10) clock_now = clock_now + $urandom_range(10, 200);
      else clock_now = clock_now + $urandom_range(0, 2);
      send_req(a, clock_now);
    end
  endtask

  initial begin
    logic [31:0] rates[6];
    logic [15:0] bursts[6];
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.ip_address <= '0;
    in_ch.now_ticks <= '0;
    quiet = 0;
    hold_sink = 0;
    clock_now = '0;
    foreach (addr_pool[i]) addr_pool[i] = $urandom;
    rates = '{32'd65536, 32'd0, 32'hFFFF_FFFF, 32'd4000, 32'd20000, 32'd1};
    bursts = '{16'd10, 16'd1, 16'hFFFF, 16'd3, 16'd0, 16'd2};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, hits, draining, time wrap
    send_req(32'h0000_0000, 48'd0);
    send_req(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_req(32'hFFFF_FFFF, 48'd0);
    send_req(32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    for (int i = 0; i < 12; i++) send_req(32'hA5A5_5A5A, 48'd5);
    send_req(32'hA5A5_5A5A, 48'd7);
    drain();
    write_reg(CFG_RATE, 32'd0);
    write_reg(CFG_BURST, 32'd0);
    write_reg(CFG_SPARE, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE_LO, 32'h1234_5678);
    send_req(32'h5A5A_A5A5, 48'd100);
    send_req(32'h5A5A_A5A5, 48'd90000);
    send_req(32'h0000_0000, 48'd90001);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_RATE, rates[p]);
      write_reg(CFG_BURST, 32'(bursts[p]));
      if (p == 2) begin
        random_traffic(100);
        hold_sink = 1;
        random_traffic(170);
      end else begin
        if (p == 5) quiet = 1;
        random_traffic(270);
      end
      drain();
    end

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
